>>> sv/fmhp_pkg.sv
package fmhp_pkg;

  // Header layout
  localparam int HdrBytes = 28;

  // Result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } fmhp_kind_e;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_HDRLEN   = 3'd3,
    ST_PAYSHORT = 3'd4,
    ST_TRAILING = 3'd5
  } fmhp_status_e;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_VERSION = 1'b0;
  localparam logic CFG_LITTLE_ENDIAN    = 1'b1;

  // One result item
  typedef struct packed {
    fmhp_kind_e   kind;
    logic [7:0]   version;
    logic [7:0]   message_type;
    logic [7:0]   flag_bits;
    logic [31:0]  session_id;
    logic [31:0]  ue_id;
    logic [31:0]  sequence_number;
    logic [63:0]  timestamp_ms;
    logic [31:0]  payload_length;
    logic [7:0]   payload_byte;
    logic         frame_done;
    fmhp_status_e status;
  } fmhp_result_t;

endpackage

>>> sv/fmhp_parse.sv
module fmhp_parse
  import fmhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         eof_i,
  input  logic [7:0]   expected_version_i,
  input  logic         little_endian_i,
  output logic         res_valid_o,
  output fmhp_result_t res_o
);

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_PAYLOAD  = 2'd1;
  localparam logic [1:0] PH_TRAILING = 2'd2;
  localparam logic [1:0] PH_DROPPING = 2'd3;

  localparam logic [4:0] LastIdx = 5'(HdrBytes - 1);

  logic [1:0]   phase_q, phase_d;
  logic [4:0]   idx_q, idx_d;
  logic [31:0]  rem_q, rem_d;
  fmhp_status_e pend_q, pend_d;
  logic [7:0]   ver_q, ver_d, type_q, type_d, flags_q, flags_d, hlen_q, hlen_d;
  logic [31:0]  sess_q, sess_d, ue_q, ue_d, seq_q, seq_d, plen_q, plen_d;
  logic [63:0]  ts_q, ts_d;
  logic         clear;
  logic [31:0]  rem_dec;
  fmhp_status_e hdr_err;

  // Place one byte into a 32-bit field
  function automatic logic [31:0] put32(logic [31:0] old, logic [7:0] b,
                                        logic [1:0] k, logic le);
    if (le) begin
      return old | ({24'd0, b} << {k, 3'b000});
    end
    return {old[23:0], b};
  endfunction

  // Place one byte into a 64-bit field
  function automatic logic [63:0] put64(logic [63:0] old, logic [7:0] b,
                                        logic [2:0] k, logic le);
    if (le) begin
      return old | ({56'd0, b} << {k, 3'b000});
    end
    return {old[55:0], b};
  endfunction

  // Route the header byte to its field
  always_comb begin
    ver_d   = ver_q;
    type_d  = type_q;
    flags_d = flags_q;
    hlen_d  = hlen_q;
    sess_d  = sess_q;
    ue_d    = ue_q;
    seq_d   = seq_q;
    ts_d    = ts_q;
    plen_d  = plen_q;
    if (idx_q == 5'd0) begin
      ver_d = byte_i;
    end else if (idx_q == 5'd1) begin
      type_d = byte_i;
    end else if (idx_q == 5'd2) begin
      flags_d = byte_i;
    end else if (idx_q == 5'd3) begin
      hlen_d = byte_i;
    end else if (idx_q < 5'd8) begin
      sess_d = put32(sess_q, byte_i, idx_q[1:0], little_endian_i);
    end else if (idx_q < 5'd12) begin
      ue_d = put32(ue_q, byte_i, idx_q[1:0], little_endian_i);
    end else if (idx_q < 5'd16) begin
      seq_d = put32(seq_q, byte_i, idx_q[1:0], little_endian_i);
    end else if (idx_q < 5'd24) begin
      ts_d = put64(ts_q, byte_i, idx_q[2:0], little_endian_i);
    end else begin
      plen_d = put32(plen_q, byte_i, idx_q[1:0], little_endian_i);
    end
  end

  // Header checks, version first
  always_comb begin
    if (ver_q != expected_version_i) begin
      hdr_err = ST_VERSION;
    end else if (hlen_q != 8'(HdrBytes)) begin
      hdr_err = ST_HDRLEN;
    end else begin
      hdr_err = ST_OK;
    end
  end

  assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;

  // Frame sequencing and result build
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    clear       = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_HEADER: begin
        idx_d = idx_q + 5'd1;
        if (idx_q != LastIdx) begin
          if (eof_i) begin
            res_valid_o     = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.frame_done = 1'b1;
            res_o.status     = ST_SHORT;
            clear            = 1'b1;
          end
        end else if (hdr_err != ST_OK) begin
          if (eof_i) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_STATUS;
            res_o.frame_done = 1'b1;
            res_o.status     = hdr_err;
            clear            = 1'b1;
          end else begin
            pend_d  = hdr_err;
            phase_d = PH_DROPPING;
          end
        end else begin
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_HEADER;
          res_o.version         = ver_q;
          res_o.message_type    = type_q;
          res_o.flag_bits       = flags_q;
          res_o.session_id      = sess_q;
          res_o.ue_id           = ue_q;
          res_o.sequence_number = seq_q;
          res_o.timestamp_ms    = ts_q;
          res_o.payload_length  = plen_d;
          if (eof_i) begin
            res_o.frame_done = 1'b1;
            res_o.status     = (plen_d == 32'd0) ? ST_OK : ST_PAYSHORT;
            clear            = 1'b1;
          end else begin
            rem_d   = plen_d;
            phase_d = (plen_d == 32'd0) ? PH_TRAILING : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d              = rem_dec;
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = byte_i;
        if (eof_i) begin
          res_o.frame_done = 1'b1;
          res_o.status     = (rem_dec == 32'd0) ? ST_OK : ST_PAYSHORT;
          clear            = 1'b1;
        end else if (rem_dec == 32'd0) begin
          phase_d = PH_TRAILING;
        end
      end
      PH_TRAILING: begin
        pend_d = ST_TRAILING;
        if (eof_i) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_STATUS;
          res_o.frame_done = 1'b1;
          res_o.status     = ST_TRAILING;
          clear            = 1'b1;
        end
      end
      PH_DROPPING: begin
        if (eof_i) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_STATUS;
          res_o.frame_done = 1'b1;
          res_o.status     = pend_q;
          clear            = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
    // Results only for accepted transfers
    res_valid_o = res_valid_o & accept_i;
  end

  // Frame state, back to the start of a frame after each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= 5'd0;
      rem_q   <= 32'd0;
      pend_q  <= ST_OK;
      ver_q   <= 8'd0;
      type_q  <= 8'd0;
      flags_q <= 8'd0;
      hlen_q  <= 8'd0;
      sess_q  <= 32'd0;
      ue_q    <= 32'd0;
      seq_q   <= 32'd0;
      ts_q    <= 64'd0;
      plen_q  <= 32'd0;
    end else if (accept_i) begin
      if (clear) begin
        phase_q <= PH_HEADER;
        idx_q   <= 5'd0;
        rem_q   <= 32'd0;
        pend_q  <= ST_OK;
        ver_q   <= 8'd0;
        type_q  <= 8'd0;
        flags_q <= 8'd0;
        hlen_q  <= 8'd0;
        sess_q  <= 32'd0;
        ue_q    <= 32'd0;
        seq_q   <= 32'd0;
        ts_q    <= 64'd0;
        plen_q  <= 32'd0;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        rem_q   <= rem_d;
        pend_q  <= pend_d;
        if (phase_q == PH_HEADER) begin
          ver_q   <= ver_d;
          type_q  <= type_d;
          flags_q <= flags_d;
          hlen_q  <= hlen_d;
          sess_q  <= sess_d;
          ue_q    <= ue_d;
          seq_q   <= seq_d;
          ts_q    <= ts_d;
          plen_q  <= plen_d;
        end
      end
    end
  end

endmodule

>>> sv/fmhp_out_slice.sv
module fmhp_out_slice
  import fmhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  fmhp_result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output fmhp_result_t data_o
);

  logic         out_valid_q, skid_valid_q;
  fmhp_result_t out_q, skid_q;
  logic         pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Control: output register backed by one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload: move skid forward or load a new transfer
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

endmodule

>>> sv/framed_message_header_parser_core.sv
// Framed message header parser. Takes one frame byte per transfer with tlast on the last
// byte, gathers the 28-byte header, checks version and header length, then emits one
// decoded header transfer and passes the declared payload bytes through; the transfer
// that closes a frame carries tlast and a status. Bad-header and trailing bytes are
// dropped and reported by a status-only transfer at frame end. The block takes one byte
// every cycle while tready is high: each byte costs one field shift and one counter
// update between the frame state and output registers; a two-entry output stage keeps
// input flowing until both entries fill and tready drops. There is no reset sweep.
module framed_message_header_parser_core
  import fmhp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  // Byte input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
  input  logic         s_axis_tlast,   // end_of_frame
  // Result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] version, [15:8] message_type, [23:16] flag_bits, [55:24] session_id,
  // [87:56] ue_id, [119:88] sequence_number, [183:120] timestamp_ms,
  // [215:184] payload_length, [223:216] payload_byte, [226:224] status, rest zero
  output logic [231:0] m_axis_tdata,
  output logic         m_axis_tlast,   // frame_done
  output logic [1:0]   m_axis_tuser    // [1:0] kind
);

  logic [7:0]   exp_ver_q;
  logic         little_endian_q;
  logic         accept;
  logic         res_valid;
  fmhp_result_t res, out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q       <= 8'd1;
      little_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_VERSION: exp_ver_q       <= cfg_data_i;
        CFG_LITTLE_ENDIAN:    little_endian_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  fmhp_parse u_parse (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .byte_i             (s_axis_tdata),
    .eof_i              (s_axis_tlast),
    .expected_version_i (exp_ver_q),
    .little_endian_i    (little_endian_q),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  fmhp_out_slice u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out)
  );

  // Pack the result onto the stream
  assign m_axis_tdata = {5'd0, out.status, out.payload_byte, out.payload_length,
                         out.timestamp_ms, out.sequence_number, out.ue_id,
                         out.session_id, out.flag_bits, out.message_type, out.version};
  assign m_axis_tlast = out.frame_done;
  assign m_axis_tuser = out.kind;

endmodule

>>> sv/fmhp_checker.sv
module fmhp_checker
  import fmhp_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic [1:0]   m_axis_tuser
);

  // Hold a stalled transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  // Header fields only on header transfers
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_HEADER |-> m_axis_tdata[215:0] == '0)
    else $error("header fields set on a non-header transfer");

  // Status only on the closing transfer
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[226:224] == '0)
    else $error("status set before frame end");

  // A status-only transfer always closes the frame
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
    else $error("status-only transfer without frame end");

endmodule

bind framed_message_header_parser_core fmhp_checker u_fmhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fmhp_pkg::*;

  localparam int StuckLimit = 1000;
  localparam int SettleCycles = 8;
  localparam int ItemTarget = 1600;
  localparam int FillRandom = 0;
  localparam int FillZeros = 1;
  localparam int FillOnes = 2;
  localparam int FieldBytes [9] = '{1, 1, 1, 1, 4, 4, 4, 8, 4};

  typedef logic [7:0] byte_q_t [$];

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILING,
    PH_DROPPING
  } frame_stage_e;

  // Tracks the parser state and holds the results each accepted byte should cause
  class header_parse_checker;
    logic [7:0]    want_version;
    logic          le_order;
    int unsigned   hdr_count;
    logic [63:0]   fields [9];
    logic [31:0]   pay_left;
    frame_stage_e  frame_stage;
    fmhp_status_e  held_status;
    fmhp_result_t  expected_results [$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      want_version = 8'd1;
      le_order = 1'b0;
      mismatches = 0;
      checked = 0;
      start_frame();
    endfunction

    function void start_frame();
      hdr_count = 0;
      foreach (fields[i]) fields[i] = '0;
      pay_left = '0;
      frame_stage = PH_HEADER;
      held_status = ST_OK;
    endfunction

    function void set_register(logic idx, logic [7:0] val);
      if (idx == CFG_EXPECTED_VERSION) begin
        want_version = val;
      end else begin
        le_order = val[0];
      end
    endfunction

    // Shift one header byte into its field, using the byte order in force now
    function void place_byte(int unsigned idx, logic [7:0] b);
      int unsigned f;
      int unsigned k;
      int unsigned width;
      if (idx < 4) begin
        f = idx;
        k = 0;
        width = 1;
      end else if (idx < 16) begin
        f = 4 + (idx - 4) / 4;
        k = (idx - 4) % 4;
        width = 4;
      end else if (idx < 24) begin
        f = 7;
        k = idx - 16;
        width = 8;
      end else begin
        f = 8;
        k = idx - 24;
        width = 4;
      end
      if (le_order) begin
        fields[f] = fields[f] | (64'(b) << (8 * k));
      end else if (width == 8) begin
        fields[f] = {fields[f][55:0], b};
      end else begin
        fields[f] = {32'd0, fields[f][23:0], b};
      end
    endfunction

    function void push_result(fmhp_kind_e kind, bit with_hdr, logic [7:0] pbyte, bit done,
                              fmhp_status_e st);
      fmhp_result_t r;
      r = '0;
      r.kind = kind;
      if (with_hdr) begin
        r.version         = fields[0][7:0];
        r.message_type    = fields[1][7:0];
        r.flag_bits       = fields[2][7:0];
        r.session_id      = fields[4][31:0];
        r.ue_id           = fields[5][31:0];
        r.sequence_number = fields[6][31:0];
        r.timestamp_ms    = fields[7];
        r.payload_length  = fields[8][31:0];
      end
      r.payload_byte = pbyte;
      r.frame_done = done;
      if (done) r.status = st;
      expected_results.push_back(r);
    endfunction

    // Advance the frame state by one accepted byte
    function void absorb_byte(logic [7:0] b, logic eof);
      fmhp_status_e err;
      case (frame_stage)
        PH_HEADER: begin
          if (hdr_count >= HdrBytes) hdr_count = 0;
          place_byte(hdr_count, b);
          hdr_count++;
          if (hdr_count < HdrBytes) begin
            if (eof) begin
              push_result(KIND_STATUS, 1'b0, 8'd0, 1'b1, ST_SHORT);
              start_frame();
            end
          end else begin
            err = ST_OK;
            if (fields[0][7:0] != want_version) begin
              err = ST_VERSION;
            end else if (fields[3][7:0] != 8'(HdrBytes)) begin
              err = ST_HDRLEN;
            end
            if (err != ST_OK) begin
              if (eof) begin
                push_result(KIND_STATUS, 1'b0, 8'd0, 1'b1, err);
                start_frame();
              end else begin
                held_status = err;
                frame_stage = PH_DROPPING;
              end
            end else if (eof) begin
              if (fields[8][31:0] == 0) begin
                push_result(KIND_HEADER, 1'b1, 8'd0, 1'b1, ST_OK);
              end else begin
                push_result(KIND_HEADER, 1'b1, 8'd0, 1'b1, ST_PAYSHORT);
              end
              start_frame();
            end else begin
              push_result(KIND_HEADER, 1'b1, 8'd0, 1'b0, ST_OK);
              pay_left = fields[8][31:0];
              frame_stage = (pay_left == 0) ? PH_TRAILING : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_left > 0) pay_left = pay_left - 1;
          if (eof) begin
            if (pay_left == 0) begin
              push_result(KIND_PAYLOAD, 1'b0, b, 1'b1, ST_OK);
            end else begin
              push_result(KIND_PAYLOAD, 1'b0, b, 1'b1, ST_PAYSHORT);
            end
            start_frame();
          end else begin
            push_result(KIND_PAYLOAD, 1'b0, b, 1'b0, ST_OK);
            if (pay_left == 0) frame_stage = PH_TRAILING;
          end
        end
        PH_TRAILING: begin
          held_status = ST_TRAILING;
          if (eof) begin
            push_result(KIND_STATUS, 1'b0, 8'd0, 1'b1, ST_TRAILING);
            start_frame();
          end
        end
        default: begin
          if (eof) begin
            push_result(KIND_STATUS, 1'b0, 8'd0, 1'b1, held_status);
            start_frame();
          end
        end
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 100) begin
        $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h", checked, what, got, want);
      end
      mismatches++;
    endtask

    task compare(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report(what, got, want);
    endtask

    // Compare one output transfer with the oldest expected result
    task check_result(logic [231:0] data, logic last, logic [1:0] user);
      fmhp_result_t w;
      checked++;
      if (expected_results.size() == 0) begin
        report("result with nothing expected", data[63:0], '0);
        return;
      end
      w = expected_results.pop_front();
      compare("kind", user, w.kind);
      compare("version", data[7:0], w.version);
      compare("message_type", data[15:8], w.message_type);
      compare("flag_bits", data[23:16], w.flag_bits);
      compare("session_id", data[55:24], w.session_id);
      compare("ue_id", data[87:56], w.ue_id);
      compare("sequence_number", data[119:88], w.sequence_number);
      compare("timestamp_ms", data[183:120], w.timestamp_ms);
      compare("payload_length", data[215:184], w.payload_length);
      compare("payload_byte", data[223:216], w.payload_byte);
      compare("status", data[226:224], w.status);
      compare("padding", data[231:227], '0);
      compare("frame_done", last, w.frame_done);
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = 1'b0;
  logic [7:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] frame_byte
  logic         s_axis_tlast = 1'b0; // end_of_frame
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [7:0] version, [15:8] message_type, [23:16] flag_bits, [55:24] session_id,
  // [87:56] ue_id, [119:88] sequence_number, [183:120] timestamp_ms,
  // [215:184] payload_length, [223:216] payload_byte, [226:224] status
  logic [231:0] m_axis_tdata;
  logic         m_axis_tlast;        // frame_done
  logic [1:0]   m_axis_tuser;        // [1:0] kind

  header_parse_checker sb;
  bit          calm = 1'b0;
  int unsigned sent_bytes = 0;
  int unsigned stuck_cycles = 0;

  framed_message_header_parser_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // End the run when neither side has moved a transfer for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Build a 28-byte header; fields other than version, length and payload length
  // are random, all zeros or all ones
  function automatic byte_q_t header_bytes(input logic [7:0] ver, input logic [7:0] hlen,
                                           input logic [31:0] plen, input bit le,
                                           input int fill);
    byte_q_t q;
    logic [63:0] vals [9];
    int i;
    int k;
    for (i = 0; i < 9; i++) begin
      if (fill == FillOnes) vals[i] = 64'hFFFF_FFFF_FFFF_FFFF;
      else if (fill == FillZeros) vals[i] = 64'd0;
      else vals[i] = {$urandom, $urandom};
    end
    vals[0] = 64'(ver);
    vals[3] = 64'(hlen);
    vals[8] = 64'(plen);
    for (i = 0; i < 9; i++) begin
      for (k = 0; k < FieldBytes[i]; k++) begin
        q.push_back(le ? vals[i][8*k +: 8] : vals[i][8*(FieldBytes[i]-1-k) +: 8]);
      end
    end
    return q;
  endfunction

  function automatic byte_q_t with_body(input byte_q_t q, input int n);
    byte_q_t r;
    int i;
    r = q;
    for (i = 0; i < n; i++) r.push_back(8'($urandom));
    return r;
  endfunction

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    logic ready;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    ready = 1'b0;
    while (!ready) begin
      @(negedge clk_i);
      ready = s_axis_tready;
      @(posedge clk_i);
    end
    sb.absorb_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_bytes(input byte_q_t q, input bit close);
    int i;
    for (i = 0; i < q.size(); i++) send_byte(q[i], close && (i == q.size() - 1));
  endtask

  // Drop valid and hold off until every expected result is out and the block settles
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic run_directed();
    byte_q_t q;
    // short headers: one byte, and one byte short of a full header
    q = {8'hFF};
    send_bytes(q, 1'b1);
    q = header_bytes(8'd1, 8'd28, 32'd0, 1'b0, FillRandom);
    send_bytes(q[0:26], 1'b1);
    // good headers ending on the last header byte, with and without declared payload
    send_bytes(header_bytes(8'd1, 8'd28, 32'd0, 1'b0, FillZeros), 1'b1);
    send_bytes(header_bytes(8'd1, 8'd28, 32'd3, 1'b0, FillRandom), 1'b1);
    // largest payload length, frame ends early
    q = header_bytes(8'd1, 8'd28, 32'hFFFF_FFFF, 1'b0, FillOnes);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    q.push_back(8'hA5);
    send_bytes(q, 1'b1);
    calm = 1'b1;
    // exact payload, short payload, trailing bytes, zero length then trailing
    q = header_bytes(8'd1, 8'd28, 32'd2, 1'b0, FillRandom);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    send_bytes(q, 1'b1);
    send_bytes(with_body(header_bytes(8'd1, 8'd28, 32'd4, 1'b0, FillRandom), 2), 1'b1);
    send_bytes(with_body(header_bytes(8'd1, 8'd28, 32'd1, 1'b0, FillRandom), 3), 1'b1);
    send_bytes(with_body(header_bytes(8'd1, 8'd28, 32'd0, 1'b0, FillRandom), 2), 1'b1);
    calm = 1'b0;
    // bad version, at once and with dropped bytes; version wins over header length
    send_bytes(header_bytes(8'd2, 8'd28, 32'd0, 1'b0, FillRandom), 1'b1);
    send_bytes(with_body(header_bytes(8'd0, 8'd28, 32'd1, 1'b0, FillRandom), 3), 1'b1);
    send_bytes(with_body(header_bytes(8'd2, 8'd0, 32'd1, 1'b0, FillRandom), 1), 1'b1);
    // bad header length, at once and with dropped bytes
    send_bytes(header_bytes(8'd1, 8'd0, 32'd0, 1'b0, FillRandom), 1'b1);
    send_bytes(with_body(header_bytes(8'd1, 8'hFF, 32'd0, 1'b0, FillRandom), 2), 1'b1);
    // switch byte order in the middle of a header
    q = header_bytes(8'd1, 8'd28, 32'd2, 1'b0, FillRandom);
    send_bytes(q[0:11], 1'b0);
    write_reg(CFG_LITTLE_ENDIAN, 8'd1);
    q = header_bytes(8'd1, 8'd28, 32'd2, 1'b1, FillRandom);
    send_bytes(with_body(q[12:27], 2), 1'b1);
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise
  task automatic send_random_frame();
    byte_q_t q;
    int pick;
    int body;
    int n;
    logic [31:0] plen;
    logic [7:0] ver;
    logic [7:0] hlen;
    bit le;
    calm = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    ver = sb.want_version;
    hlen = 8'(HdrBytes);
    le = sb.le_order;
    if ($urandom_range(0, 15) == 0) le = !le;
    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    body = plen;
    if (pick < 55) begin
      body = plen;
    end else if (pick < 65) begin
      plen = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 12);
      body = (plen > 10) ? $urandom_range(0, 10) : $urandom_range(0, plen - 1);
    end else if (pick < 75) begin
      body = plen + $urandom_range(1, 4);
    end else if (pick < 90) begin
      if (pick < 83) ver = ver ^ 8'($urandom_range(1, 255));
      else hlen = hlen ^ 8'($urandom_range(1, 255));
      body = $urandom_range(0, 5);
    end
    q = with_body(header_bytes(ver, hlen, plen, le, FillRandom), body);
    if (pick >= 95) begin
      q.delete();
      q = with_body(q, $urandom_range(1, 40));
    end else if (pick >= 90) begin
      n = $urandom_range(1, 27);
      q = q[0:n-1];
    end
    send_bytes(q, 1'b1);
  endtask

  // Take results with a random stall before each one
  initial begin : result_sink
    int stall;
    logic got;
    logic [231:0] d;
    logic l;
    logic [1:0] u;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      got = 1'b0;
      while (!got) begin
        @(negedge clk_i);
        got = m_axis_tvalid;
        d = m_axis_tdata;
        l = m_axis_tlast;
        u = m_axis_tuser;
        @(posedge clk_i);
      end
      sb.check_result(d, l, u);
    end
  end

  initial begin : stimulus
    int phase_no;
    logic [7:0] ver;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    // sweep register settings, extremes first
    phase_no = 0;
    while (sent_bytes < ItemTarget) begin
      case (phase_no % 4)
        0: ver = 8'd0;
        1: ver = 8'd255;
        2: ver = 8'd1;
        default: ver = 8'($urandom);
      endcase
      write_reg(CFG_EXPECTED_VERSION, ver);
      write_reg(CFG_LITTLE_ENDIAN, 8'((phase_no + phase_no / 4) % 2));
      repeat (10) send_random_frame();
      phase_no++;
    end
    wait_quiet();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> framed_message_header_parser_core.f
sv/fmhp_pkg.sv
sv/fmhp_parse.sv
sv/fmhp_out_slice.sv
sv/framed_message_header_parser_core.sv
sv/fmhp_checker.sv
test/tb_top.sv
